// ----- hw/rtl/rpw_pkg.sv -----
package rpw_pkg;

  // field widths
  localparam int BYTES_W  = 48;
  localparam int TIME_W   = 32;
  localparam int FRAMES_W = 32;
  localparam int PEAK_W   = 16;
  localparam int VERDICT_W = 3;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;

  // stream layout
  localparam int IN_TDATA_W  = 136;
  localparam int OUT_TDATA_W = 8;

  localparam int BYTES_LO   = 0;
  localparam int ELAPSED_LO = BYTES_LO + BYTES_W;
  localparam int DISK_BIT   = ELAPSED_LO + TIME_W;
  localparam int FRAMES_LO  = DISK_BIT + 1;
  localparam int PVALID_BIT = FRAMES_LO + FRAMES_W;
  localparam int PEAK_LO    = PVALID_BIT + 1;

  // header margin in bytes, one bit wider than the byte count
  localparam logic [BYTES_W:0] HEADER_MARGIN = (BYTES_W + 1)'(8192 * 4);

  // commands
  localparam logic CMD_ARM     = 1'b0;
  localparam logic CMD_OBSERVE = 1'b1;

  // verdict codes
  localparam logic [VERDICT_W-1:0] VERDICT_TOO_EARLY = 3'd0;
  localparam logic [VERDICT_W-1:0] VERDICT_NOTHING   = 3'd1;
  localparam logic [VERDICT_W-1:0] VERDICT_STALLED   = 3'd2;
  localparam logic [VERDICT_W-1:0] VERDICT_NO_SOUND  = 3'd3;
  localparam logic [VERDICT_W-1:0] VERDICT_HEALTHY   = 3'd4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GRACE_TIME   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STALL_TIME   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SILENCE_TIME = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SILENCE_FLOOR = 2'd3;

  // reset values
  localparam logic [TIME_W-1:0] GRACE_TIME_RST   = 32'd3000;
  localparam logic [TIME_W-1:0] STALL_TIME_RST   = 32'd5000;
  localparam logic [TIME_W-1:0] SILENCE_TIME_RST = 32'd20000;
  localparam logic [PEAK_W-1:0] SILENCE_FLOOR_RST = 16'd33;

  typedef struct packed {
    logic                command;
    logic [PEAK_W-1:0]   peak_level;
    logic                peak_valid;
    logic [FRAMES_W-1:0] frames_accepted;
    logic                disk_seen;
    logic [TIME_W-1:0]   elapsed_ms;
    logic [BYTES_W-1:0]  bytes_on_disk;
  } item_t;

  typedef struct packed {
    logic [TIME_W-1:0] grace_time_ms;
    logic [TIME_W-1:0] stall_time_ms;
    logic [TIME_W-1:0] silence_time_ms;
    logic [PEAK_W-1:0] silence_floor;
  } cfg_t;

endpackage

// ----- hw/rtl/rpw_cfg_regs.sv -----
module rpw_cfg_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [rpw_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rpw_pkg::CFG_DATA_W-1:0]   cfg_data,
  output rpw_pkg::cfg_t                    cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.grace_time_ms   <= rpw_pkg::GRACE_TIME_RST;
      cfg.stall_time_ms   <= rpw_pkg::STALL_TIME_RST;
      cfg.silence_time_ms <= rpw_pkg::SILENCE_TIME_RST;
      cfg.silence_floor   <= rpw_pkg::SILENCE_FLOOR_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        rpw_pkg::REG_GRACE_TIME:    cfg.grace_time_ms   <= cfg_data;
        rpw_pkg::REG_STALL_TIME:    cfg.stall_time_ms   <= cfg_data;
        rpw_pkg::REG_SILENCE_TIME:  cfg.silence_time_ms <= cfg_data;
        rpw_pkg::REG_SILENCE_FLOOR: cfg.silence_floor   <= cfg_data[rpw_pkg::PEAK_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- hw/rtl/rpw_judge.sv -----
module rpw_judge (
  input  logic                              clk,
  input  logic                              rst,
  input  rpw_pkg::cfg_t                     cfg,
  input  rpw_pkg::item_t                    item,
  input  logic                              fire,
  output logic [rpw_pkg::VERDICT_W-1:0]     verdict
);

  logic                         armed;
  logic [rpw_pkg::BYTES_W-1:0]  bytes_at_arm;
  logic [rpw_pkg::BYTES_W-1:0]  last_byte_count;
  logic [rpw_pkg::TIME_W-1:0]   last_growth_ms;
  logic                         growth_seen;
  logic                         silence_said;

  logic                         observe;
  logic                         grow;
  logic [rpw_pkg::TIME_W-1:0]   growth_ms_now;
  logic                         growth_seen_now;
  logic [rpw_pkg::BYTES_W:0]    arm_limit;
  logic                         early;
  logic                         nothing;
  logic                         stall;
  logic                         no_sound;

  assign observe = (item.command == rpw_pkg::CMD_OBSERVE);
  assign grow    = item.disk_seen && (item.bytes_on_disk > last_byte_count);

  // growth is taken into account before any check
  assign growth_ms_now   = grow ? item.elapsed_ms : last_growth_ms;
  assign growth_seen_now = growth_seen | grow;

  assign arm_limit = {1'b0, bytes_at_arm} + rpw_pkg::HEADER_MARGIN;

  assign early   = item.elapsed_ms < cfg.grace_time_ms;
  assign nothing = item.disk_seen &&
                   (!growth_seen_now ||
                    (({1'b0, item.bytes_on_disk} <= arm_limit) &&
                     (item.frames_accepted == '0)));
  // time going backwards never counts as a stall
  assign stall   = item.disk_seen && (item.elapsed_ms >= growth_ms_now) &&
                   ((item.elapsed_ms - growth_ms_now) >= cfg.stall_time_ms);
  assign no_sound = !silence_said && (item.elapsed_ms >= cfg.silence_time_ms) &&
                    item.peak_valid && (item.peak_level < cfg.silence_floor);

  always_comb begin
    if (!armed || early) begin
      verdict = rpw_pkg::VERDICT_TOO_EARLY;
    end else if (nothing) begin
      verdict = rpw_pkg::VERDICT_NOTHING;
    end else if (stall) begin
      verdict = rpw_pkg::VERDICT_STALLED;
    end else if (no_sound) begin
      verdict = rpw_pkg::VERDICT_NO_SOUND;
    end else begin
      verdict = rpw_pkg::VERDICT_HEALTHY;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      armed        <= 1'b0;
      growth_seen  <= 1'b0;
      silence_said <= 1'b0;
    end else if (fire) begin
      if (!observe) begin
        armed        <= 1'b1;
        growth_seen  <= 1'b0;
        silence_said <= 1'b0;
      end else if (armed) begin
        growth_seen <= growth_seen_now;
        if (verdict == rpw_pkg::VERDICT_NO_SOUND) begin
          silence_said <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      if (!observe) begin
        bytes_at_arm    <= item.bytes_on_disk;
        last_byte_count <= item.bytes_on_disk;
        last_growth_ms  <= item.elapsed_ms;
      end else if (armed && grow) begin
        last_byte_count <= item.bytes_on_disk;
        last_growth_ms  <= item.elapsed_ms;
      end
    end
  end

endmodule

// ----- hw/rtl/recording_progress_watchdog_unit.sv -----
// Recording progress watchdog: judges whether a recording that writes to
// storage is alive. A word with tuser = 0 arms the monitor (latches byte
// count and time, clears the growth and silence flags) and gives no result.
// A word with tuser = 1 is an observation and gives exactly one verdict word:
// 0 too early, 1 nothing written, 2 stalled, 3 no sound (once per arm),
// 4 healthy. One word is taken every clock cycle unless a stalled verdict
// blocks an observation; a verdict leaves from the result register. The
// watchdog state is updated as a word leaves the input register, so
// consecutive words see each other's effect with no gap. While a verdict
// waits, one more word can be taken into the input register; arm words
// never wait for the output. The user must write configuration registers via
// cfg_we / cfg_index / cfg_data only while idle; the block does not check.
module recording_progress_watchdog_unit (
  input  logic                                  clk,
  input  logic                                  rst,
  // input stream
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // tdata from bit 0: bytes_on_disk[47:0], elapsed_ms[79:48], disk_seen[80],
  // frames_accepted[112:81], peak_valid[113], peak_level[129:114], zeros
  input  logic [rpw_pkg::IN_TDATA_W-1:0]        s_axis_tdata,
  // tuser: command (0 arm, 1 observe)
  input  logic                                  s_axis_tuser,
  // result stream
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // tdata from bit 0: verdict[2:0], zeros
  output logic [rpw_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,
  // configuration write port
  input  logic                                  cfg_we,
  input  logic [rpw_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [rpw_pkg::CFG_DATA_W-1:0]        cfg_data
);

  rpw_pkg::cfg_t   cfg;
  rpw_pkg::item_t  in_item;
  logic            in_valid;
  logic            in_is_arm;
  logic            advance;
  logic [rpw_pkg::VERDICT_W-1:0] verdict_next;
  logic [rpw_pkg::VERDICT_W-1:0] verdict;

  rpw_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // an arm word leaves without a result; an observation needs the result
  // register empty or being drained this cycle
  assign in_is_arm = (in_item.command == rpw_pkg::CMD_ARM);
  assign advance   = in_valid && (in_is_arm || !m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item.command         <= s_axis_tuser;
      in_item.bytes_on_disk   <= s_axis_tdata[rpw_pkg::BYTES_LO +: rpw_pkg::BYTES_W];
      in_item.elapsed_ms      <= s_axis_tdata[rpw_pkg::ELAPSED_LO +: rpw_pkg::TIME_W];
      in_item.disk_seen       <= s_axis_tdata[rpw_pkg::DISK_BIT];
      in_item.frames_accepted <= s_axis_tdata[rpw_pkg::FRAMES_LO +: rpw_pkg::FRAMES_W];
      in_item.peak_valid      <= s_axis_tdata[rpw_pkg::PVALID_BIT];
      in_item.peak_level      <= s_axis_tdata[rpw_pkg::PEAK_LO +: rpw_pkg::PEAK_W];
    end
  end

  // verdict logic and watchdog state, updated on advance
  rpw_judge u_judge (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .item    (in_item),
    .fire    (advance),
    .verdict (verdict_next)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance && !in_is_arm) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && !in_is_arm) begin
      verdict <= verdict_next;
    end
  end

  assign m_axis_tdata = {{(rpw_pkg::OUT_TDATA_W - rpw_pkg::VERDICT_W){1'b0}}, verdict};

endmodule

// ----- hw/rtl/rpw_checker.sv -----
module rpw_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              s_axis_tready,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [rpw_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

  // a stalled verdict word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("verdict word changed while stalled");

  // verdict code in range, upper bits zero
  a_verdict_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata <= {5'd0, rpw_pkg::VERDICT_HEALTHY}))
    else $error("verdict out of range");

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  // input only backs up when a verdict is waiting downstream
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without a waiting verdict");

endmodule

bind recording_progress_watchdog_unit rpw_checker u_rpw_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ----- bench/tb.sv -----
`timescale 1ns / 100ps

module tb;
  import rpw_pkg::*;

  // cycles with no accepted word before the run is called hung
  localparam int HANG_LIMIT = 4000;
  // quiet cycles after the last verdict, covers the two-stage pipe
  localparam int SETTLE_CYCLES = 6;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // input stream, all driven from time zero
  logic                  s_valid = 1'b0;
  logic                  s_ready;
  logic [IN_TDATA_W-1:0] s_data = '0;
  logic                  s_user = 1'b0;

  // result stream
  logic                   m_valid;
  logic                   m_ready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_data;

  // configuration port
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  always #1 clk = ~clk;

  recording_progress_watchdog_unit DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),
    .s_axis_tuser  (s_user),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // local copy of the configuration registers
  logic [TIME_W-1:0] grace_ms   = GRACE_TIME_RST;
  logic [TIME_W-1:0] stall_ms   = STALL_TIME_RST;
  logic [TIME_W-1:0] silence_ms = SILENCE_TIME_RST;
  logic [PEAK_W-1:0] floor_lvl  = SILENCE_FLOOR_RST;

  // local copy of the watchdog state
  logic               is_armed    = 1'b0;
  logic [BYTES_W-1:0] arm_bytes   = '0;
  logic [BYTES_W-1:0] top_bytes   = '0;
  logic [TIME_W-1:0]  grow_ms     = '0;
  logic               grew        = 1'b0;
  logic               silence_told = 1'b0;

  // verdicts still owed by the block, oldest first
  logic [VERDICT_W-1:0] verdicts_due[$];
  logic [VERDICT_W-1:0] verdict_want;

  int mismatch_count = 0;
  int words_sent = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hang_count = 0;

  // ---------------------------------------------------------------------
  // verdict prediction, run when a word is accepted
  // ---------------------------------------------------------------------
  task automatic judge_word(input item_t w);
    logic [VERDICT_W-1:0] v;
    logic                 quiet_disk;
    if (w.command == CMD_ARM) begin
      // arm latches the baseline and gives no verdict
      is_armed     = 1'b1;
      arm_bytes    = w.bytes_on_disk;
      top_bytes    = w.bytes_on_disk;
      grow_ms      = w.elapsed_ms;
      grew         = 1'b0;
      silence_told = 1'b0;
      return;
    end
    if (!is_armed) begin
      v = VERDICT_TOO_EARLY;
    end else begin
      // growth is recorded first, even inside the grace time
      if (w.disk_seen && w.bytes_on_disk > top_bytes) begin
        top_bytes = w.bytes_on_disk;
        grow_ms   = w.elapsed_ms;
        grew      = 1'b1;
      end
      // header margin sum is one bit wider, so it never wraps
      quiet_disk = ({1'b0, w.bytes_on_disk} <= ({1'b0, arm_bytes} + HEADER_MARGIN))
                   && (w.frames_accepted == '0);
      if (w.elapsed_ms < grace_ms) begin
        v = VERDICT_TOO_EARLY;
      end else if (w.disk_seen && (!grew || quiet_disk)) begin
        v = VERDICT_NOTHING;
      end else if (w.disk_seen && w.elapsed_ms >= grow_ms &&
                   (w.elapsed_ms - grow_ms) >= stall_ms) begin
        // time going backwards never counts as a stall
        v = VERDICT_STALLED;
      end else if (!silence_told && w.elapsed_ms >= silence_ms &&
                   w.peak_valid && w.peak_level < floor_lvl) begin
        silence_told = 1'b1;
        v = VERDICT_NO_SOUND;
      end else begin
        v = VERDICT_HEALTHY;
      end
    end
    verdicts_due.push_back(v);
  endtask

  // ---------------------------------------------------------------------
  // sender: one word per call, random gaps before it
  // ---------------------------------------------------------------------
  task automatic send_word(input item_t w);
    logic [IN_TDATA_W-1:0] d;
    // valid stays high if no gap is drawn, so back-to-back words stream
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_valid <= 1'b0;
      @(posedge clk);
    end
    d = '0;
    d[BYTES_LO +: BYTES_W]    = w.bytes_on_disk;
    d[ELAPSED_LO +: TIME_W]   = w.elapsed_ms;
    d[DISK_BIT]               = w.disk_seen;
    d[FRAMES_LO +: FRAMES_W]  = w.frames_accepted;
    d[PVALID_BIT]             = w.peak_valid;
    d[PEAK_LO +: PEAK_W]      = w.peak_level;
    s_valid <= 1'b1;
    s_user  <= w.command;
    s_data  <= d;
    do @(posedge clk); while (!s_ready);
    judge_word(w);
    words_sent++;
  endtask

  function automatic item_t make_word(input logic cmd, input logic [BYTES_W-1:0] b,
                                      input logic [TIME_W-1:0] t, input logic disk,
                                      input logic [FRAMES_W-1:0] frames, input logic pv,
                                      input logic [PEAK_W-1:0] peak);
    item_t w;
    w.command         = cmd;
    w.bytes_on_disk   = b;
    w.elapsed_ms      = t;
    w.disk_seen       = disk;
    w.frames_accepted = frames;
    w.peak_valid      = pv;
    w.peak_level      = peak;
    return w;
  endfunction

  // drop valid and let every owed verdict come out, then a few quiet cycles
  task automatic settle_block();
    s_valid <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------
  // configuration writes, only while the block is idle
  // ---------------------------------------------------------------------
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_GRACE_TIME:    grace_ms   = val;
      REG_STALL_TIME:    stall_ms   = val;
      REG_SILENCE_TIME:  silence_ms = val;
      REG_SILENCE_FLOOR: floor_lvl  = val[PEAK_W-1:0];
      default: ;
    endcase
  endtask

  // floor register gets random junk in its unused upper bits
  task automatic set_config(input logic [TIME_W-1:0] grace, input logic [TIME_W-1:0] stall,
                            input logic [TIME_W-1:0] silence, input logic [PEAK_W-1:0] lvl);
    logic [CFG_DATA_W-PEAK_W-1:0] junk;
    junk = (CFG_DATA_W - PEAK_W)'($urandom);
    write_reg(REG_GRACE_TIME, grace);
    write_reg(REG_STALL_TIME, stall);
    write_reg(REG_SILENCE_TIME, silence);
    write_reg(REG_SILENCE_FLOOR, {junk, lvl});
  endtask

  task automatic pick_config();
    logic [TIME_W-1:0] g, s, q;
    logic [PEAK_W-1:0] f;
    int r;
    r = $urandom_range(0, 9);
    g = (r == 0) ? '0 : (r == 1) ? TIME_W'($urandom_range(0, 100)) :
        TIME_W'($urandom_range(0, 4000));
    r = $urandom_range(0, 9);
    s = (r == 0) ? '0 : (r == 1) ? '1 : TIME_W'($urandom_range(500, 10000));
    r = $urandom_range(0, 9);
    q = (r == 0) ? '0 : TIME_W'($urandom_range(0, 20000));
    r = $urandom_range(0, 9);
    f = (r < 2) ? PEAK_W'($urandom) : PEAK_W'($urandom_range(0, 200));
    set_config(g, s, q, f);
  endtask

  // ---------------------------------------------------------------------
  // one recording: arm, then observations with time and bytes moving on
  // ---------------------------------------------------------------------
  task automatic run_session(input int n_obs);
    logic [BYTES_W-1:0] b;
    logic [TIME_W-1:0]  t;
    logic [PEAK_W-1:0]  peak;
    int r;
    r = $urandom_range(0, 9);
    if (r < 6)      b = BYTES_W'($urandom_range(0, 100000));
    else if (r < 9) b = {16'($urandom), 32'($urandom)};
    else            b = '1 - BYTES_W'($urandom_range(0, 70000));
    t = ($urandom_range(0, 9) < 8) ? TIME_W'($urandom_range(0, 2000)) : TIME_W'($urandom);
    send_word(make_word(CMD_ARM, b, t, 1'($urandom), $urandom, 1'($urandom),
                        16'($urandom)));
    repeat (n_obs) begin
      if ($urandom_range(0, 9) == 0) begin
        // noise word, any command and any content
        send_word(make_word(1'($urandom), {16'($urandom), 32'($urandom)}, $urandom,
                            1'($urandom), $urandom, 1'($urandom), 16'($urandom)));
      end else begin
        r = $urandom_range(0, 99);
        if (r < 8)       t = t - TIME_W'($urandom_range(0, 3000));
        else if (r < 18) t = t + TIME_W'($urandom_range(5000, 30000));
        else             t = t + TIME_W'($urandom_range(0, 2500));
        r = $urandom_range(0, 99);
        if (r < 35)      ;
        else if (r < 60) b = b + BYTES_W'($urandom_range(1, 40000));
        else if (r < 95) b = b + BYTES_W'($urandom_range(1, 1 << 20));
        else             b = b - BYTES_W'($urandom_range(1, 1000));
        peak = ($urandom_range(0, 1) == 0) ? PEAK_W'($urandom_range(0, 64)) :
               PEAK_W'($urandom);
        send_word(make_word(CMD_OBSERVE, b, t, $urandom_range(0, 9) != 0,
                            ($urandom_range(0, 99) < 15) ? '0 : FRAMES_W'($urandom),
                            $urandom_range(0, 3) != 0, peak));
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // test: hand-picked words under the reset configuration
  // ---------------------------------------------------------------------
  task automatic test_directed_cases();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    // observations before any arm are too early, whatever they carry
    send_word(make_word(CMD_OBSERVE, '0, '0, 1'b0, '0, 1'b0, '0));
    send_word(make_word(CMD_OBSERVE, '1, '1, 1'b1, '1, 1'b1, '1));
    send_word(make_word(CMD_ARM, '0, '0, 1'b0, '0, 1'b0, '0));
    // growth inside the grace time still moves the baseline
    send_word(make_word(CMD_OBSERVE, 48'd20000, 32'd1000, 1'b1, '0, 1'b0, '0));
    send_word(make_word(CMD_OBSERVE, 48'd20000, 32'd3000, 1'b1, '0, 1'b0, '0));
    // exactly on the header margin with no frames is still nothing written
    send_word(make_word(CMD_OBSERVE, 48'd32768, 32'd3100, 1'b1, '0, 1'b0, '0));
    send_word(make_word(CMD_OBSERVE, 48'd32769, 32'd3200, 1'b1, '0, 1'b0, '0));
    // one short of the stall time, then on it
    send_word(make_word(CMD_OBSERVE, 48'd32769, 32'd8199, 1'b1, 32'd7, 1'b0, '0));
    send_word(make_word(CMD_OBSERVE, 48'd32769, 32'd8200, 1'b1, 32'd7, 1'b0, '0));
    // no disk reading skips both disk checks
    send_word(make_word(CMD_OBSERVE, 48'd32769, 32'd8300, 1'b0, 32'd7, 1'b0, '0));
    // peak equal to the floor is not silence, one below is
    send_word(make_word(CMD_OBSERVE, 48'd32769, 32'd20000, 1'b0, 32'd7, 1'b1, 16'd33));
    send_word(make_word(CMD_OBSERVE, 48'd32769, 32'd20000, 1'b0, 32'd7, 1'b1, 16'd32));
    // silence is reported once per arm
    send_word(make_word(CMD_OBSERVE, 48'd32769, 32'd20001, 1'b0, 32'd7, 1'b1, 16'd0));
    // time earlier than the last growth never stalls
    send_word(make_word(CMD_OBSERVE, 48'd32769, 32'd3199, 1'b1, 32'd7, 1'b1, 16'd0));
    // re-arm at the top of the byte range clears the silence flag
    send_word(make_word(CMD_ARM, '1, 32'hFFFF_FFF0, 1'b1, '1, 1'b1, '1));
    send_word(make_word(CMD_OBSERVE, '1, '1, 1'b1, '1, 1'b1, '1));
    send_word(make_word(CMD_OBSERVE, '1, '1, 1'b0, '1, 1'b1, '0));
    send_word(make_word(CMD_OBSERVE, '1, '1, 1'b0, '1, 1'b0, '1));
    // margin sum near the top of the range must not wrap
    send_word(make_word(CMD_ARM, 48'hFFFF_FFFF_0000, 32'd5000, 1'b0, '0, 1'b0, '0));
    send_word(make_word(CMD_OBSERVE, 48'hFFFF_FFFF_8000, 32'd6000, 1'b1, '0, 1'b0, '0));
    send_word(make_word(CMD_OBSERVE, '1, 32'd6000, 1'b1, '0, 1'b0, '0));
    send_word(make_word(CMD_OBSERVE, '1, 32'd11000, 1'b1, '0, 1'b0, '0));
    settle_block();
  endtask

  // ---------------------------------------------------------------------
  // test: sender waits for every verdict before the next word
  // ---------------------------------------------------------------------
  task automatic test_paced_sender();
    logic [BYTES_W-1:0] b;
    logic [TIME_W-1:0]  t;
    send_idle_pct  = 0;
    recv_stall_pct = 78;
    b = BYTES_W'($urandom_range(0, 1000));
    t = '0;
    send_word(make_word(CMD_ARM, b, t, 1'b1, '0, 1'b0, '0));
    settle_block();
    repeat (20) begin
      t = t + TIME_W'($urandom_range(0, 4000));
      if ($urandom_range(0, 1)) b = b + BYTES_W'($urandom_range(1, 60000));
      send_word(make_word(CMD_OBSERVE, b, t, 1'($urandom), $urandom, 1'($urandom),
                          PEAK_W'($urandom_range(0, 64))));
      settle_block();
    end
  endtask

  // ---------------------------------------------------------------------
  // test: register extremes, a few recordings under each
  // ---------------------------------------------------------------------
  task automatic test_config_extremes();
    logic [TIME_W-1:0] g[8]   = '{'0, '1, '0, '1, 32'd1000, 32'd0, GRACE_TIME_RST, 32'd0};
    logic [TIME_W-1:0] s[8]   = '{'0, '1, '1, '0, 32'd0, 32'd3000, STALL_TIME_RST, '1};
    logic [TIME_W-1:0] q[8]   = '{'0, '1, '0, '1, 32'd0, 32'd10000, SILENCE_TIME_RST, '1};
    logic [PEAK_W-1:0] f[8]   = '{'0, '1, '1, '0, '1, 16'd40, SILENCE_FLOOR_RST, 16'd33};
    for (int i = 0; i < 8; i++) begin
      // cycle through the idle patterns so every setting but i % 4 == 0 sees pressure
      send_idle_pct  = (i % 4 == 1 || i % 4 == 3) ? ((i % 4 == 1) ? 78 : 6) : 0;
      recv_stall_pct = (i % 4 == 2 || i % 4 == 3) ? ((i % 4 == 2) ? 78 : 6) : 0;
      set_config(g[i], s[i], q[i], f[i]);
      repeat (3) run_session($urandom_range(5, 15));
      settle_block();
    end
  endtask

  // ---------------------------------------------------------------------
  // test: long random traffic under each idle pattern
  // ---------------------------------------------------------------------
  task automatic test_random_traffic();
    int mark;
    for (int mode = 0; mode < 4; mode++) begin
      case (mode)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 78; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 78; end
        default: begin send_idle_pct = 6; recv_stall_pct = 6; end
      endcase
      repeat (2) begin
        pick_config();
        mark = words_sent;
        while (words_sent - mark < 100) run_session($urandom_range(3, 20));
        settle_block();
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // receiver stalls and verdict checking
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    if (!rst && m_valid && m_ready) begin
      if (verdicts_due.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected verdict word %0d with nothing owed", m_data[VERDICT_W-1:0]);
      end else begin
        verdict_want = verdicts_due.pop_front();
        if (m_data[VERDICT_W-1:0] !== verdict_want) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("verdict mismatch: expected %0d, got %0d",
                     verdict_want, m_data[VERDICT_W-1:0]);
        end
      end
    end
  end

  // hang detector: any accepted word on either side restarts the count
  always @(posedge clk) begin
    if ((s_valid && s_ready) || (m_valid && m_ready)) begin
      hang_count <= 0;
    end else if (hang_count >= HANG_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      hang_count <= hang_count + 1;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_directed_cases();
    test_paced_sender();
    test_config_extremes();
    test_random_traffic();
    settle_block();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && verdicts_due.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
